FILE: rtl/nearest_neighbor_flipped_remap_core_macros.svh
// Assertion macros used by the RTL of the remap core.
`ifndef NEAREST_NEIGHBOR_FLIPPED_REMAP_CORE_MACROS_SVH
`define NEAREST_NEIGHBOR_FLIPPED_REMAP_CORE_MACROS_SVH
`ifndef SYNTH
`define NNFR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define NNFR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define NNFR_ASSERT(lbl, clk, rstn, prop, msg)
`define NNFR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: rtl/nnfr_pkg.sv
`default_nettype none
package nnfr_pkg;

  localparam int unsigned QUOT_BITS = 10;
  localparam logic [3:0]  DIV_LAST_STEP = 4'd9;

  localparam logic [10:0] SRC_MAX = 11'd1024;
  localparam logic [12:0] DST_MAX = 13'd4096;

  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EMIT = 1'b1;

  typedef struct packed {
    logic        action;
    logic [13:0] src_index;
    logic [15:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [23:0] dst_index;
    logic [15:0] pixel_out;
    logic        last;
  } out_item_t;

endpackage
`default_nettype wire

FILE: rtl/nnfr_stream_if.sv
`default_nettype none
interface nnfr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/nearest_neighbor_flipped_remap_core.sv
// Load transactions can be accepted back to back. An emit transaction steps
// through the multiply, divide, source-index, destination-index and read
// states, the shared restoring divider computing both quotients in turn; the
// next transaction is taken only once its result enters the output register,
// which waits on a stalled output. Reset clears the controller, raster counters
// and sets all four image dimensions to 1; the pixel store holds no reset value.
`default_nettype none
`include "nearest_neighbor_flipped_remap_core_macros.svh"
module nearest_neighbor_flipped_remap_core #(
  parameter int SRC_DEPTH  = 16384,
  parameter int PIXEL_BITS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [12:0] cfg_wdata_i,
  nnfr_stream_if.sink   in_i,
  nnfr_stream_if.source out_o
);

  localparam int AW = $clog2(SRC_DEPTH);
  localparam logic [20:0] DEPTH_LIM = 21'(SRC_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SIDX = 3'd3;
  localparam logic [2:0] S_DIDX = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;

  logic [PIXEL_BITS-1:0] store_q [SRC_DEPTH];
  logic [PIXEL_BITS-1:0] rdata_q;

  logic [2:0]  state_q, state_d;
  logic        ph_q;
  logic [3:0]  cnt_q;
  logic [10:0] src_width_q, src_height_q;
  logic [12:0] dst_width_q, dst_height_q;
  logic [11:0] out_col_q, out_row_q;
  logic        out_valid_q;

  logic [11:0] col_q, row_q;
  logic        last_q;
  logic [12:0] div_rem_q;
  localparam int QUOT_BITS_W = nnfr_pkg::QUOT_BITS;
  logic [QUOT_BITS_W-1:0] div_low_q;
  logic [9:0]  sx_q, sy_q;
  logic [19:0] sidx_q;
  logic        sidx_ok_q;
  logic [23:0] didx_q;
  nnfr_pkg::out_item_t out_q;

  logic [10:0] sw_c, sh_c;
  logic [12:0] dw_c, dh_c, divisor_c;
  logic        in_acc, load_ok, out_load;
  logic [11:0] col_start, row_start;
  logic        col_last, row_last;
  logic [11:0] mul_a, mul_c;
  logic [12:0] mul_b;
  logic [24:0] mul_p;
  logic [12:0] trial, rem_d;
  logic        ge;
  logic [9:0]  low_d;

  always_comb begin
    sw_c = (src_width_q == 11'd0) ? 11'd1 :
           (src_width_q > nnfr_pkg::SRC_MAX) ? nnfr_pkg::SRC_MAX : src_width_q;
    sh_c = (src_height_q == 11'd0) ? 11'd1 :
           (src_height_q > nnfr_pkg::SRC_MAX) ? nnfr_pkg::SRC_MAX : src_height_q;
    dw_c = (dst_width_q == 13'd0) ? 13'd1 :
           (dst_width_q > nnfr_pkg::DST_MAX) ? nnfr_pkg::DST_MAX : dst_width_q;
    dh_c = (dst_height_q == 13'd0) ? 13'd1 :
           (dst_height_q > nnfr_pkg::DST_MAX) ? nnfr_pkg::DST_MAX : dst_height_q;
    divisor_c = ph_q ? dh_c : dw_c;
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign load_ok     = {7'b0, in_i.data.src_index} < DEPTH_LIM;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
  assign out_load    = (state_q == S_RD) && (!out_valid_q || out_o.ready);

  always_comb begin
    col_start = ({1'b0, out_col_q} >= dw_c) ? 12'd0 : out_col_q;
    row_start = ({1'b0, out_row_q} >= dh_c) ? 12'd0 : out_row_q;
    col_last  = ({1'b0, col_start} == dw_c - 13'd1);
    row_last  = ({1'b0, row_start} == dh_c - 13'd1);
  end

  always_comb begin
    mul_a = 12'd0;
    mul_b = 13'd0;
    mul_c = 12'd0;
    unique case (state_q)
      S_MUL: begin
        mul_a = ph_q ? row_q : col_q;
        mul_b = ph_q ? {2'b0, sh_c} : {2'b0, sw_c};
      end
      S_SIDX: begin
        mul_a = 12'(sh_c - 11'd1 - {1'b0, sy_q});
        mul_b = {2'b0, sw_c};
        mul_c = {2'b0, sx_q};
      end
      S_DIDX: begin
        mul_a = 12'(dh_c - 13'd1 - {1'b0, row_q});
        mul_b = dw_c;
        mul_c = col_q;
      end
      default: begin
      end
    endcase
    mul_p = {13'b0, mul_a} * {12'b0, mul_b} + {13'b0, mul_c};
  end

  always_comb begin
    trial = {div_rem_q[11:0], div_low_q[9]};
    ge    = trial >= divisor_c;
    rem_d = ge ? trial - divisor_c : trial;
    low_d = {div_low_q[8:0], ge};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_i.data.action == nnfr_pkg::ACT_EMIT) begin
          state_d = S_MUL;
        end
      end
      S_MUL: state_d = S_DIV;
      S_DIV: begin
        if (cnt_q == nnfr_pkg::DIV_LAST_STEP) begin
          state_d = ph_q ? S_SIDX : S_MUL;
        end
      end
      S_SIDX: state_d = S_DIDX;
      S_DIDX: state_d = S_RD;
      S_RD: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ph_q         <= 1'b0;
      cnt_q        <= 4'd0;
      src_width_q  <= 11'd1;
      src_height_q <= 11'd1;
      dst_width_q  <= 13'd1;
      dst_height_q <= 13'd1;
      out_col_q    <= 12'd0;
      out_row_q    <= 12'd0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          nnfr_pkg::REG_SRC_WIDTH:  src_width_q  <= cfg_wdata_i[10:0];
          nnfr_pkg::REG_SRC_HEIGHT: src_height_q <= cfg_wdata_i[10:0];
          nnfr_pkg::REG_DST_WIDTH:  dst_width_q  <= cfg_wdata_i;
          nnfr_pkg::REG_DST_HEIGHT: dst_height_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (in_acc && in_i.data.action == nnfr_pkg::ACT_EMIT) begin
        ph_q      <= 1'b0;
        out_col_q <= col_last ? 12'd0 : col_start + 12'd1;
        out_row_q <= col_last ? (row_last ? 12'd0 : row_start + 12'd1) : row_start;
      end
      if (state_q == S_MUL) begin
        cnt_q <= 4'd0;
      end else if (state_q == S_DIV) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == nnfr_pkg::DIV_LAST_STEP) begin
          ph_q <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.data.action == nnfr_pkg::ACT_EMIT) begin
      col_q  <= col_start;
      row_q  <= row_start;
      last_q <= col_last && row_last;
    end
    if (state_q == S_MUL) begin
      div_rem_q <= mul_p[22:10];
      div_low_q <= mul_p[9:0];
    end else if (state_q == S_DIV) begin
      div_rem_q <= rem_d;
      div_low_q <= low_d;
      if (cnt_q == nnfr_pkg::DIV_LAST_STEP) begin
        if (ph_q) begin
          sy_q <= low_d;
        end else begin
          sx_q <= low_d;
        end
      end
    end
    if (state_q == S_SIDX) begin
      sidx_q    <= mul_p[19:0];
      sidx_ok_q <= {1'b0, mul_p[19:0]} < DEPTH_LIM;
    end
    if (state_q == S_DIDX) begin
      didx_q <= mul_p[23:0];
    end
    if (out_load) begin
      out_q.dst_index <= didx_q;
      out_q.pixel_out <= sidx_ok_q ? 16'(rdata_q) : 16'd0;
      out_q.last      <= last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.data.action == nnfr_pkg::ACT_LOAD && load_ok) begin
      store_q[AW'(in_i.data.src_index)] <= PIXEL_BITS'(in_i.data.pixel_in);
    end
    if (state_q == S_DIDX) begin
      rdata_q <= store_q[sidx_q[AW-1:0]];
    end
  end

  `NNFR_ASSERT_IMP(a_div_rem_below, clk_i, rst_ni, state_q == S_DIV, div_rem_q < divisor_c, "divider remainder reached the divisor")
  `NNFR_ASSERT_IMP(a_valid_from_rd, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == S_RD, "result appeared outside the read state")
  `NNFR_ASSERT_IMP(a_coord_range, clk_i, rst_ni, state_q == S_SIDX, ({1'b0, sx_q} < sw_c) && ({1'b0, sy_q} < sh_c), "source coordinate out of range")
  `NNFR_ASSERT_IMP(a_last_index, clk_i, rst_ni, out_valid_q && out_q.last, out_q.dst_index == {11'b0, dw_c - 13'd1}, "final pixel has a wrong destination index")

endmodule
`default_nettype wire
